// ----- rtl/hst_pkg.sv -----
// Shared types and constants for the Hermite spline tessellator.
// No dependencies; every other file refers to this package by scoped names.
package hst_pkg;

  // Q1.16 basis weights, signed to carry the negative outgoing-tangent term
  localparam int WEIGHT_BITS = 18;
  localparam int FRAC_BITS   = 16;
  localparam int ROUND_HALF  = 32768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT,
    ST_SHIFT
  } state_t;

  // product term taken by the shared multiplier in one MAC cycle
  typedef enum logic [1:0] {
    TERM_CHORD,  // w01 * (p2 - p1)
    TERM_TAN0,   // w10 * (p2 - p0)
    TERM_TAN1    // w11 * (p3 - p1)
  } term_t;

  typedef struct packed {
    logic  acc_clr;
    logic  mac_en;
    logic  mac_first;
    term_t term;
    logic  emit;
    logic  last;
    logic  raw;
    logic  raw_new;
    logic  span_b;
    logic  shift;
  } ctrl_t;

endpackage

// ----- rtl/hst_lane.sv -----
// One coordinate lane: shared multiply-accumulate over the three basis terms,
// then rounding, base add and saturation. Depends on hst_pkg.
module hst_lane #(
  parameter int COORD_BITS = 32
) (
  input  logic                                        clk,
  input  hst_pkg::ctrl_t                              ctl,
  input  logic signed [hst_pkg::WEIGHT_BITS-1:0]      weight,
  input  logic signed [COORD_BITS-1:0]                p0,
  input  logic signed [COORD_BITS-1:0]                p1,
  input  logic signed [COORD_BITS-1:0]                p2,
  input  logic signed [COORD_BITS-1:0]                p3,
  input  logic signed [COORD_BITS-1:0]                base,
  output logic signed [COORD_BITS-1:0]                result
);

  localparam int PW = COORD_BITS + 1 + hst_pkg::WEIGHT_BITS;
  localparam int AW = PW + 1;
  localparam int SW = AW - hst_pkg::FRAC_BITS;
  localparam int TW = COORD_BITS + 5;

  logic signed [COORD_BITS-1:0] opa;
  logic signed [COORD_BITS-1:0] opb;
  logic signed [COORD_BITS:0]   diff;
  logic signed [PW-1:0]         prod;
  logic signed [AW-1:0]         acc;
  logic signed [AW-1:0]         acc_next;
  logic signed [AW-1:0]         rnd;
  logic signed [SW-1:0]         shifted;
  logic signed [TW-1:0]         total;
  logic signed [TW-1:0]         sat_max;
  logic signed [TW-1:0]         sat_min;

  always_comb begin
    case (ctl.term)
      hst_pkg::TERM_CHORD: begin
        opa = p2;
        opb = p1;
      end
      hst_pkg::TERM_TAN0: begin
        opa = p2;
        opb = p0;
      end
      hst_pkg::TERM_TAN1: begin
        opa = p3;
        opb = p1;
      end
      default: begin
        opa = p1;
        opb = p1;
      end
    endcase
  end

  assign diff = (COORD_BITS+1)'(opa) - (COORD_BITS+1)'(opb);
  assign prod = PW'(diff) * PW'(weight);

  always_comb begin
    if (ctl.mac_first) begin
      acc_next = AW'(prod);
    end else begin
      acc_next = acc + AW'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.mac_en) begin
      acc <= acc_next;
    end
  end

  // round half up, then back to Q23.8 on top of p1
  assign rnd     = acc + AW'(hst_pkg::ROUND_HALF);
  assign shifted = rnd[AW-1:hst_pkg::FRAC_BITS];
  assign total   = TW'(shifted) + TW'(base);
  assign sat_max = $signed({{6{1'b0}}, {(COORD_BITS-1){1'b1}}});
  assign sat_min = $signed({{6{1'b1}}, {(COORD_BITS-1){1'b0}}});

  always_comb begin
    if (total > sat_max) begin
      result = sat_max[COORD_BITS-1:0];
    end else if (total < sat_min) begin
      result = sat_min[COORD_BITS-1:0];
    end else begin
      result = total[COORD_BITS-1:0];
    end
  end

endmodule

// ----- rtl/hst_seq.sv -----
// Sequencer: plans the vertices caused by one point and steps the shared
// MAC lanes through terms, samples and spans. Depends on hst_pkg.
module hst_seq #(
  parameter int SEGMENT_STEPS = 16,
  parameter int JW            = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           final_point,
  input  logic [1:0]     held_count,
  input  logic           spline_en,
  input  logic           out_free,
  output logic           in_ready,
  output logic           fin,
  output logic [JW-1:0]  j,
  output hst_pkg::ctrl_t ctl
);

  hst_pkg::state_t state, state_next;
  hst_pkg::term_t  term, term_next;
  logic [JW-1:0]   j_next;
  logic            fin_next;
  logic            raw, raw_next;
  logic            raw_new, raw_new_next;
  logic            span_b, span_b_next;
  logic            last;
  logic            j_end;

  assign j_end = (j == JW'(SEGMENT_STEPS));
  assign last  = raw ? raw_new : (j_end && (span_b || !fin));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hst_pkg::ST_IDLE;
      term    <= hst_pkg::TERM_CHORD;
      j       <= '0;
      fin     <= 1'b0;
      raw     <= 1'b0;
      raw_new <= 1'b0;
      span_b  <= 1'b0;
    end else begin
      state   <= state_next;
      term    <= term_next;
      j       <= j_next;
      fin     <= fin_next;
      raw     <= raw_next;
      raw_new <= raw_new_next;
      span_b  <= span_b_next;
    end
  end

  always_comb begin
    state_next   = state;
    term_next    = term;
    j_next       = j;
    fin_next     = fin;
    raw_next     = raw;
    raw_new_next = raw_new;
    span_b_next  = span_b;
    in_ready     = 1'b0;
    ctl          = '0;
    ctl.term     = term;
    ctl.last     = last;
    ctl.raw      = raw;
    ctl.raw_new  = raw_new;
    ctl.span_b   = span_b;

    unique case (state)
      hst_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.acc_clr = 1'b1;
        if (in_valid) begin
          fin_next    = final_point;
          j_next      = '0;
          term_next   = hst_pkg::TERM_CHORD;
          span_b_next = 1'b0;
          if (held_count == 2'd0) begin
            state_next = hst_pkg::ST_SHIFT;
          end else if (held_count == 2'd1) begin
            // two points pass through, or wait for a third
            raw_next     = 1'b1;
            raw_new_next = 1'b0;
            state_next   = (final_point || !spline_en) ? hst_pkg::ST_EMIT
                                                       : hst_pkg::ST_SHIFT;
          end else if (!spline_en) begin
            raw_next     = 1'b1;
            raw_new_next = 1'b1;
            state_next   = hst_pkg::ST_EMIT;
          end else begin
            raw_next   = 1'b0;
            state_next = hst_pkg::ST_MAC;
          end
        end
      end
      hst_pkg::ST_MAC: begin
        ctl.mac_en    = 1'b1;
        ctl.mac_first = (term == hst_pkg::TERM_CHORD);
        case (term)
          hst_pkg::TERM_CHORD: term_next = hst_pkg::TERM_TAN0;
          hst_pkg::TERM_TAN0:  term_next = hst_pkg::TERM_TAN1;
          hst_pkg::TERM_TAN1: begin
            term_next  = hst_pkg::TERM_CHORD;
            state_next = hst_pkg::ST_EMIT;
          end
          default: term_next = hst_pkg::TERM_CHORD;
        endcase
      end
      hst_pkg::ST_EMIT: begin
        if (out_free) begin
          ctl.emit = 1'b1;
          if (last) begin
            state_next = hst_pkg::ST_SHIFT;
          end else if (raw) begin
            raw_new_next = 1'b1;
          end else if (j_end) begin
            // trailing span with the last point duplicated
            span_b_next = 1'b1;
            j_next      = '0;
            state_next  = hst_pkg::ST_MAC;
          end else begin
            j_next     = j + JW'(1);
            state_next = hst_pkg::ST_MAC;
          end
        end
      end
      hst_pkg::ST_SHIFT: begin
        ctl.shift  = 1'b1;
        state_next = hst_pkg::ST_IDLE;
      end
      default: state_next = hst_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/hermite_spline_tessellator.sv -----
// Top level of the Hermite spline tessellator: point history, weight tables,
// output register and config. Depends on hst_pkg, hst_lane and hst_seq.
//
// Usage:
//   Points enter on the in_valid/in_ready channel, one beat per control point,
//   final_point set on the last point of a polyline. Vertices leave on the
//   out_valid/out_ready channel; run_end marks the last vertex caused by a
//   point and line_end the last vertex of the line.
//   The spline_enable register is written through cfg_valid/cfg_ready/cfg_data;
//   the user must write it only while the block is idle, as the block itself
//   does not enforce this; cfg_ready is always high. Each coordinate has its
//   own lane with one multiplier that is reused for the three basis terms: a
//   vertex takes one MAC state per term, then is rounded and loaded into the
//   output register in the emit state; a span yields SEGMENT_STEPS+1 vertices.
//   A final point may cause two spans. Pass-through points skip the MAC states,
//   and a point that only gets stored goes straight to the shift state. One
//   point is worked on at a time: in_ready is high only while the sequencer
//   is idle. A spline point's first vertex is registered after its MAC states.
//   A stalled receiver holds the output register and the sequencer waits on
//   it. Reset empties the point history and sets spline_enable to 1.
module hermite_spline_tessellator #(
  parameter int SEGMENT_STEPS = 16,
  parameter int COORD_BITS    = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic                         final_point,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] vertex_x,
  output logic signed [COORD_BITS-1:0] vertex_y,
  output logic signed [COORD_BITS-1:0] vertex_z,
  output logic                         run_end,
  output logic                         line_end,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data
);

  localparam int JW = $clog2(SEGMENT_STEPS + 1);
  localparam int WB = hst_pkg::WEIGHT_BITS;

  hst_pkg::ctrl_t ctl;
  logic [JW-1:0]  j;
  logic           fin;
  logic           spline_en;
  logic [1:0]     held_count;
  logic           out_free;

  logic signed [COORD_BITS-1:0] pt_in  [3];
  logic signed [COORD_BITS-1:0] new_pt [3];
  logic signed [COORD_BITS-1:0] held   [3][3];
  logic signed [COORD_BITS-1:0] lane_out [3];

  logic signed [WB-1:0] w_chord_tab [SEGMENT_STEPS+1];
  logic signed [WB-1:0] w_tan0_tab  [SEGMENT_STEPS+1];
  logic signed [WB-1:0] w_tan1_tab  [SEGMENT_STEPS+1];
  logic signed [WB-1:0] weight;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign pt_in[0]  = point_x;
  assign pt_in[1]  = point_y;
  assign pt_in[2]  = point_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      spline_en <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      spline_en <= cfg_data;
    end
  end

  // Q1.16 Hermite weights for t = j/S, rounded half away from zero
  for (genvar gj = 0; gj <= SEGMENT_STEPS; gj++) begin : g_wtab
    localparam longint JL = longint'(gj);
    localparam longint SL = longint'(SEGMENT_STEPS);
    localparam longint S3 = SL * SL * SL;
    localparam longint NC = 65536 * (3 * JL * JL * SL - 2 * JL * JL * JL);
    localparam longint N0 = 65536 * (JL * JL * JL - 2 * JL * JL * SL + JL * SL * SL);
    localparam longint N1 = 65536 * (JL * JL * SL - JL * JL * JL);
    localparam longint WC = (2 * NC + S3) / (2 * S3);
    localparam longint W0 = (2 * N0 + S3) / (2 * S3);
    localparam longint W1 = -((2 * N1 + S3) / (2 * S3));
    assign w_chord_tab[gj] = WB'(WC);
    assign w_tan0_tab[gj]  = WB'(W0);
    assign w_tan1_tab[gj]  = WB'(W1);
  end

  always_comb begin
    case (ctl.term)
      hst_pkg::TERM_CHORD: weight = w_chord_tab[j];
      hst_pkg::TERM_TAN0:  weight = w_tan0_tab[j];
      hst_pkg::TERM_TAN1:  weight = w_tan1_tab[j];
      default:             weight = '0;
    endcase
  end

  hst_seq #(
    .SEGMENT_STEPS (SEGMENT_STEPS),
    .JW            (JW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .final_point (final_point),
    .held_count  (held_count),
    .spline_en   (spline_en),
    .out_free    (out_free),
    .in_ready    (in_ready),
    .fin         (fin),
    .j           (j),
    .ctl         (ctl)
  );

  // point history; the newest point is held apart until the item ends
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (ctl.shift) begin
      if (fin) begin
        held_count <= 2'd0;
      end else if (held_count != 2'd3) begin
        held_count <= held_count + 2'd1;
      end
    end
  end

  for (genvar ga = 0; ga < 3; ga++) begin : g_axis
    logic signed [COORD_BITS-1:0] p0;
    logic signed [COORD_BITS-1:0] p1;
    logic signed [COORD_BITS-1:0] p2;
    logic signed [COORD_BITS-1:0] base;

    always_ff @(posedge clk) begin
      if (in_valid && in_ready) begin
        new_pt[ga] <= pt_in[ga];
      end
      if (ctl.shift) begin
        held[ga][0] <= held[ga][1];
        held[ga][1] <= held[ga][2];
        held[ga][2] <= new_pt[ga];
      end
    end

    // first span duplicates the line's first point
    always_comb begin
      if (ctl.span_b) begin
        p0 = held[ga][1];
        p1 = held[ga][2];
        p2 = new_pt[ga];
      end else begin
        p0 = (held_count == 2'd2) ? held[ga][1] : held[ga][0];
        p1 = held[ga][1];
        p2 = held[ga][2];
      end
      if (ctl.raw) begin
        base = ctl.raw_new ? new_pt[ga] : held[ga][2];
      end else begin
        base = p1;
      end
    end

    hst_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .weight (weight),
      .p0     (p0),
      .p1     (p1),
      .p2     (p2),
      .p3     (new_pt[ga]),
      .base   (base),
      .result (lane_out[ga])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      vertex_x <= lane_out[0];
      vertex_y <= lane_out[1];
      vertex_z <= lane_out[2];
      run_end  <= ctl.last;
      line_end <= ctl.last && fin;
    end
  end

`ifndef ASSERT_OFF
  a_one_point: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second point accepted while one is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!out_valid || out_ready))
    else $error("output register loaded while a beat is still held");

  a_line_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_end) |-> run_end)
    else $error("line_end without run_end");
`endif

endmodule
